/* rtl/core/tagged_field_header_encoder_defines.svh */
// assertion macros shared by the encoder rtl
`ifndef TAGGED_FIELD_HEADER_ENCODER_DEFINES_SVH
`define TAGGED_FIELD_HEADER_ENCODER_DEFINES_SVH

// same-cycle implication
`define TFHE_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tfhe assertion failed");

// next-cycle implication
`define TFHE_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tfhe assertion failed");

`endif

/* rtl/core/tfhe_pkg.sv */
package tfhe_pkg;

    localparam int TAG_GRPS   = 5;
    localparam int NUM_GRPS   = 10;
    localparam int STEPS      = 2;
    localparam int NSTAGE     = (NUM_GRPS + STEPS - 1) / STEPS;
    localparam int TN_W       = 3;
    localparam int NN_W       = 4;

    localparam logic [6:0]  GROUP_MASK      = 7'h7F;
    localparam logic [4:0]  LONG_TAG_MARK   = 5'b11111;
    localparam logic [31:0] SHORT_TAG_LIMIT = 32'd31;

    typedef struct packed {
        logic                         is_long;
        logic                         has_num;
        logic [7:0]                   hdr;
        logic [31:0]                  tv;
        logic [TN_W-1:0]              tn;
        logic                         tdone;
        logic [TAG_GRPS-1:0][7:0]     tg;
        logic [63:0]                  nv;
        logic [NN_W-1:0]              nn;
        logic                         ndone;
        logic [NUM_GRPS-1:0][7:0]     ng;
    } t_work;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HDR,
        ST_TAG,
        ST_NUM
    } t_state;

    // first-stage view of a fresh word
    function automatic t_work work_init(logic [31:0] tag, logic [2:0] typ,
                                        logic has, logic [63:0] num);
        t_work w;
        w         = '0;
        w.is_long = (tag >= SHORT_TAG_LIMIT);
        w.has_num = has;
        w.hdr     = w.is_long ? {LONG_TAG_MARK, typ} : {tag[4:0], typ};
        w.tv      = tag;
        w.nv      = num;
        return w;
    endfunction

    // group steps that belong to stage s; group k is peeled off at step k
    function automatic t_work stage_step(t_work w, int s);
        t_work r;
        int    k;
        r = w;
        for (int j = 0; j < STEPS; j++) begin
            k = s * STEPS + j;
            if (k < NUM_GRPS && !r.ndone) begin
                r.ng[k] = {(k != 0), r.nv[6:0]};
                r.nn    = NN_W'(k + 1);
                if (r.nv <= 64'(GROUP_MASK)) begin
                    r.ndone = 1'b1;
                end else begin
                    r.nv = (r.nv >> 7) - 64'd1;
                end
            end
            if (k < TAG_GRPS && !r.tdone) begin
                r.tg[k] = {(k != 0), r.tv[6:0]};
                r.tn    = TN_W'(k + 1);
                if (r.tv <= 32'(GROUP_MASK)) begin
                    r.tdone = 1'b1;
                end else begin
                    r.tv = (r.tv >> 7) - 32'd1;
                end
            end
        end
        return r;
    endfunction

endpackage

/* rtl/core/tagged_field_header_encoder.sv */
// channel  direction  handshake            payload
// input    in         i_valid / o_stall    i_field_tag, i_type_code, i_has_number, i_number
// output   out        o_valid / i_stall    o_out_byte, o_last_byte
//
// each input word gives 1 header byte, 0 or 1..5 tag bytes and 0 or 1..10 number bytes,
// one per cycle while i_stall is low, so the byte serialiser sets the word rate
// varint groups are peeled off in a 5-stage pipeline, two groups per stage, and the
// first byte passes the stage registers, the serialiser word register and the output register
// reset is synchronous, active low, and clears valid bits and serialiser state
// i_stall holds the output register, the serialiser waits and the pipeline backs up to o_stall
`include "tagged_field_header_encoder_defines.svh"

module tagged_field_header_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_field_tag,
    input  logic [2:0]  i_type_code,
    input  logic        i_has_number,
    input  logic [63:0] i_number,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte
);

    logic                  w_pv;
    tfhe_pkg::t_work       w_pw;
    logic                  w_load;
    logic                  w_fire;
    logic                  w_last;
    logic [7:0]            w_byte;

    tfhe_pkg::t_state      r_state;
    tfhe_pkg::t_state      n_state;
    logic [tfhe_pkg::NN_W-1:0] r_idx;
    logic [tfhe_pkg::NN_W-1:0] n_idx;
    tfhe_pkg::t_work       r_w;
    logic                  r_ov;
    logic [7:0]            r_byte;
    logic                  r_last;

    tfhe_pipe u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_field_tag  (i_field_tag),
        .i_type_code  (i_type_code),
        .i_has_number (i_has_number),
        .i_number     (i_number),
        .o_valid      (w_pv),
        .o_work       (w_pw),
        .i_take       (w_load)
    );

    assign w_fire = (r_state != tfhe_pkg::ST_IDLE) && (!r_ov || !i_stall);

    // byte selection and walk through the groups, most significant first
    always_comb begin
        w_byte  = '0;
        w_last  = 1'b0;
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            tfhe_pkg::ST_IDLE: begin
                w_byte = '0;
            end
            tfhe_pkg::ST_HDR: begin
                w_byte = r_w.hdr;
                if (r_w.is_long) begin
                    n_state = tfhe_pkg::ST_TAG;
                    n_idx   = {1'b0, r_w.tn - 3'd1};
                end else if (r_w.has_num) begin
                    n_state = tfhe_pkg::ST_NUM;
                    n_idx   = r_w.nn - 4'd1;
                end else begin
                    w_last = 1'b1;
                end
            end
            tfhe_pkg::ST_TAG: begin
                w_byte = r_w.tg[r_idx[2:0]];
                if (r_idx == '0) begin
                    if (r_w.has_num) begin
                        n_state = tfhe_pkg::ST_NUM;
                        n_idx   = r_w.nn - 4'd1;
                    end else begin
                        w_last = 1'b1;
                    end
                end else begin
                    n_idx = r_idx - 4'd1;
                end
            end
            tfhe_pkg::ST_NUM: begin
                w_byte = r_w.ng[r_idx];
                if (r_idx == '0) begin
                    w_last = 1'b1;
                end else begin
                    n_idx = r_idx - 4'd1;
                end
            end
            default: begin
                w_byte = '0;
            end
        endcase
        if (!w_fire) begin
            n_state = r_state;
            n_idx   = r_idx;
        end else if (w_last) begin
            n_state = tfhe_pkg::ST_IDLE;
        end
        if (w_load) begin
            n_state = tfhe_pkg::ST_HDR;
        end
    end

    assign w_load = w_pv && ((r_state == tfhe_pkg::ST_IDLE) || (w_fire && w_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tfhe_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_w <= w_pw;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_fire) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_byte <= w_byte;
            r_last <= w_last;
        end
    end

    assign o_valid     = r_ov;
    assign o_out_byte  = r_byte;
    assign o_last_byte = r_last;

    `TFHE_ASSERT_IMP(a_tag_long, i_clk, i_rst_n, r_state == tfhe_pkg::ST_TAG,
                     r_w.is_long && (r_idx < {1'b0, r_w.tn}))
    `TFHE_ASSERT_IMP(a_num_has, i_clk, i_rst_n, r_state == tfhe_pkg::ST_NUM,
                     r_w.has_num && (r_idx < r_w.nn))
    `TFHE_ASSERT_NXT(a_fire_out, i_clk, i_rst_n, w_fire, r_ov && (r_last == $past(w_last)))
    `TFHE_ASSERT_IMP(a_load_slot, i_clk, i_rst_n, w_load, (r_state == tfhe_pkg::ST_IDLE) || w_last)

endmodule

/* rtl/core/tfhe_pipe.sv */
module tfhe_pipe (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [31:0]          i_field_tag,
    input  logic [2:0]           i_type_code,
    input  logic                 i_has_number,
    input  logic [63:0]          i_number,
    output logic                 o_valid,
    output tfhe_pkg::t_work      o_work,
    input  logic                 i_take
);

    logic           r_v   [tfhe_pkg::NSTAGE];
    tfhe_pkg::t_work r_w  [tfhe_pkg::NSTAGE];
    tfhe_pkg::t_work w_nx [tfhe_pkg::NSTAGE];
    logic           w_en  [tfhe_pkg::NSTAGE];

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_en[tfhe_pkg::NSTAGE-1] = !r_v[tfhe_pkg::NSTAGE-1] || i_take;
        for (int s = tfhe_pkg::NSTAGE - 2; s >= 0; s--) begin
            w_en[s] = !r_v[s] || w_en[s+1];
        end
    end

    assign w_nx[0] = tfhe_pkg::stage_step(
        tfhe_pkg::work_init(i_field_tag, i_type_code, i_has_number, i_number), 0);

    for (genvar s = 1; s < tfhe_pkg::NSTAGE; s++) begin : g_stage
        assign w_nx[s] = tfhe_pkg::stage_step(r_w[s-1], s);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < tfhe_pkg::NSTAGE; s++) begin
                r_v[s] <= 1'b0;
            end
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int s = 1; s < tfhe_pkg::NSTAGE; s++) begin
                if (w_en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < tfhe_pkg::NSTAGE; s++) begin
            if (w_en[s]) begin
                r_w[s] <= w_nx[s];
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[tfhe_pkg::NSTAGE-1];
    assign o_work  = r_w[tfhe_pkg::NSTAGE-1];

endmodule

/* tb/tagged_field_header_encoder_tb.sv */
`timescale 1ns / 100ps

module tagged_field_header_encoder_tb;

    localparam logic [7:0]  LONG_MARK   = 8'hF8;
    localparam logic [31:0] SHORT_LIMIT = 32'd31;
    localparam logic [6:0]  GROUP       = 7'h7F;
    localparam logic [7:0]  CONT        = 8'h80;
    localparam int          MAX_GROUPS  = 10;
    localparam int          QUIET_LIMIT = 3000;
    localparam int          HOLD_CYCLES = 400;
    localparam int          DRAIN_WAIT  = 40;

    typedef struct packed {
        logic [7:0] val;
        logic       last;
    } t_enc_byte;

    // fix holds up to three typed bytes, first byte in the top octet
    typedef struct packed {
        logic [31:0] tag;
        logic [2:0]  typ;
        logic        has;
        logic [63:0] num;
        logic [1:0]  nfix;
        logic [23:0] fix;
    } t_dir_row;

    typedef enum logic [1:0] {
        RX_RANDOM,
        RX_FREE,
        RX_HOLD
    } t_rx_mode;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic        o_stall;
    logic [31:0] i_field_tag  = '0;
    logic [2:0]  i_type_code  = '0;
    logic        i_has_number = 1'b0;
    logic [63:0] i_number     = '0;
    logic        o_valid;
    logic        i_stall      = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_byte;

    t_enc_byte   pending_bytes [$];
    t_enc_byte   due;
    int          mismatches   = 0;
    int          quiet_cycles = 0;
    int          hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          tx_gaps      = 1'b1;
    t_rx_mode    rx_mode      = RX_RANDOM;

    t_dir_row dir_rows [0:17] = '{
        '{32'd0,          3'd0, 1'b0, 64'd0,                  2'd1, 24'h00_0000},
        '{32'd30,         3'd7, 1'b0, 64'd0,                  2'd1, 24'hF7_0000},
        '{32'd31,         3'd0, 1'b0, 64'd0,                  2'd2, 24'hF8_1F00},
        '{32'd31,         3'd5, 1'b1, 64'd0,                  2'd3, 24'hFD_1F00},
        '{32'd5,          3'd2, 1'b1, 64'd0,                  2'd2, 24'h2A_0000},
        '{32'd1,          3'd3, 1'b1, 64'd127,                2'd2, 24'h0B_7F00},
        '{32'd17,         3'd1, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 2'd1, 24'h89_0000},
        '{32'd2,          3'd7, 1'b1, 64'd1,                  2'd2, 24'h17_0100},
        '{32'd3,          3'd4, 1'b1, 64'd128,                2'd0, 24'h00_0000},
        '{32'hFFFF_FFFF,  3'd7, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 2'd0, 24'h00_0000},
        '{32'hFFFF_FFFF,  3'd0, 1'b0, 64'd0,                  2'd0, 24'h00_0000},
        '{32'h8000_0000,  3'd6, 1'b1, 64'h8000_0000_0000_0000, 2'd0, 24'h00_0000},
        '{32'd127,        3'd1, 1'b1, 64'd16383,              2'd0, 24'h00_0000},
        '{32'd128,        3'd2, 1'b1, 64'd16384,              2'd0, 24'h00_0000},
        '{32'd16511,      3'd3, 1'b1, 64'd16512,              2'd0, 24'h00_0000},
        '{32'h7FFF_FFFF,  3'd4, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 2'd0, 24'h00_0000},
        '{32'd32,         3'd5, 1'b1, 64'd255,                2'd0, 24'h00_0000},
        '{32'd29,         3'd6, 1'b1, 64'h0123_4567_89AB_CDEF, 2'd0, 24'h00_0000}
    };

    tagged_field_header_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_field_tag  (i_field_tag),
        .i_type_code  (i_type_code),
        .i_has_number (i_has_number),
        .i_number     (i_number),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_byte   (o_out_byte),
        .o_last_byte  (o_last_byte)
    );

    always #1 i_clk = ~i_clk;

    task automatic flag_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // groups are peeled from the low end with a minus-one offset, sent high end first
    task automatic append_varint(ref logic [7:0] seq [$], input logic [63:0] value);
        logic [7:0]  grp [MAX_GROUPS];
        logic [63:0] v;
        int          n;
        v = value;
        n = 0;
        forever begin
            grp[n] = ((n > 0) ? CONT : 8'h00) | {1'b0, v[6:0]};
            n++;
            if (v <= {57'd0, GROUP} || n >= MAX_GROUPS) break;
            v = (v >> 7) - 64'd1;
        end
        while (n > 0) begin
            n--;
            seq.push_back(grp[n]);
        end
    endtask

    task automatic predict_header(input logic [31:0] tag, input logic [2:0] typ,
                                  input logic has, input logic [63:0] num);
        logic [7:0] seq [$];
        seq = {};
        if (tag >= SHORT_LIMIT) begin
            seq.push_back(LONG_MARK | {5'd0, typ});
            append_varint(seq, {32'd0, tag});
        end else begin
            seq.push_back({tag[4:0], typ});
        end
        if (has) begin
            append_varint(seq, num);
        end
        for (int k = 0; k < seq.size(); k++) begin
            pending_bytes.push_back({seq[k], k == seq.size() - 1});
        end
    endtask

    // returns at the edge where the word is taken
    task automatic offer_field(input logic [31:0] tag, input logic [2:0] typ,
                               input logic has, input logic [63:0] num);
        i_valid      <= 1'b1;
        i_field_tag  <= tag;
        i_type_code  <= typ;
        i_has_number <= has;
        i_number     <= num;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic maybe_pause();
        if (tx_gaps && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(input bit wide);
        logic [31:0] tag;
        logic [2:0]  typ;
        logic        has;
        logic [63:0] num;
        case (wide ? 3 : $urandom_range(3))
            0: begin
                tag = $urandom_range(30);
            end
            1: begin
                tag = $urandom_range(40, 24);
            end
            2: begin
                tag = $urandom >> $urandom_range(31);
            end
            default: begin
                tag = $urandom;
            end
        endcase
        typ = $urandom_range(7);
        has = wide || ($urandom_range(3) != 0);
        num = {$urandom, $urandom};
        if (!wide && $urandom_range(3) != 0) begin
            num = num >> $urandom_range(63);
        end
        offer_field(tag, typ, has, num);
        predict_header(tag, typ, has, num);
        maybe_pause();
    endtask

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (rx_mode == RX_HOLD && !hold_done) begin
            i_stall   <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (rx_mode == RX_FREE) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 25);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_bytes.size() == 0) begin
                flag_mismatch($sformatf("byte %02h with nothing outstanding", o_out_byte));
            end else begin
                due = pending_bytes.pop_front();
                if (o_out_byte !== due.val) begin
                    flag_mismatch($sformatf("out_byte %02h, wanted %02h",
                                            o_out_byte, due.val));
                end
                if (o_last_byte !== due.last) begin
                    flag_mismatch($sformatf("last_byte %b, wanted %b on byte %02h",
                                            o_last_byte, due.last, due.val));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            offer_field(dir_rows[r].tag, dir_rows[r].typ, dir_rows[r].has, dir_rows[r].num);
            if (dir_rows[r].nfix != 0) begin
                for (int k = 0; k < dir_rows[r].nfix; k++) begin
                    pending_bytes.push_back({dir_rows[r].fix[23 - 8 * k -: 8],
                                             k == dir_rows[r].nfix - 1});
                end
            end else begin
                predict_header(dir_rows[r].tag, dir_rows[r].typ, dir_rows[r].has,
                               dir_rows[r].num);
            end
            maybe_pause();
        end

        repeat (150) send_random(1'b0);

        // back-to-back stretch on both sides
        tx_gaps = 1'b0;
        rx_mode <= RX_FREE;
        repeat (100) send_random(1'b0);

        // sender waits for every outstanding byte
        i_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);

        // long receiver hold while long words keep coming, so the input backs up
        rx_mode <= RX_HOLD;
        repeat (60) send_random(1'b1);
        rx_mode <= RX_RANDOM;
        tx_gaps = 1'b1;

        repeat (160) send_random(1'b0);
        i_valid <= 1'b0;

        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
